/* src/slpl_pkg.sv */
// Shared constants, types and helper functions for the stereo peak limiter.
`default_nettype none

package slpl_pkg;

  // Storage geometry
  localparam int DELAY_LEN   = 480;
  localparam int AVG_LEN     = 120;
  localparam int SAMPLE_BITS = 24;
  localparam int DLY_AW      = $clog2(DELAY_LEN);
  localparam int AVG_AW      = $clog2(AVG_LEN);
  localparam int SCAN_W      = $clog2(DELAY_LEN + 1);

  // Number formats
  localparam int ENV_W   = 28;
  localparam int GAIN_W  = 24;
  localparam int DVD_W   = 48;
  localparam int DIVC_W  = $clog2(DVD_W);

  localparam logic [ENV_W-1:0]  ENV_MAX   = {ENV_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 24'h800000;

  // Reciprocals for the averaging divisions, tied to AVG_LEN of 120:
  // sum/120 is (sum>>3)/15 = ((sum>>3)*DIV15_MUL)>>35, exact for 32-bit operands;
  // oldest/121 is (oldest*DIV121_MUL)>>36, exact for 28-bit operands
  localparam logic [31:0] DIV15_MUL  = 32'h8888_8889;
  localparam logic [31:0] DIV121_MUL = 32'd567929561;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ATTACK  = 3'd0,
    CFG_RELEASE = 3'd1,
    CFG_THRESH  = 3'd2,
    CFG_MAKEUP  = 3'd3,
    CFG_BETA    = 3'd4,
    CFG_INVB    = 3'd5,
    CFG_BYPASS  = 3'd6
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MUL_B,
    S_MUL_T,
    S_CORR,
    S_MUL_E,
    S_ENV,
    S_MUL_S,
    S_MUL_O,
    S_AVG,
    S_DIV,
    S_DIV_END,
    S_MUL_L1,
    S_MUL_L2,
    S_SAT_L,
    S_MUL_R1,
    S_MUL_R2,
    S_SAT_R,
    S_WRITE,
    S_DONE
  } state_t;

  // Magnitude of a signed sample, one bit wider
  function automatic logic [SAMPLE_BITS:0] mag(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS:0] m;
    if (v[SAMPLE_BITS-1]) begin
      m = (SAMPLE_BITS+1)'(1 << SAMPLE_BITS) - {1'b0, v};
    end else begin
      m = {1'b0, v};
    end
    return m;
  endfunction

  // Restore sign and saturate a scaled magnitude to the sample range
  function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic [30:0] q, input logic neg);
    logic [SAMPLE_BITS-1:0] qc;
    if (neg) begin
      qc = (q > 31'(1 << (SAMPLE_BITS-1))) ? SAMPLE_BITS'(1 << (SAMPLE_BITS-1))
                                            : q[SAMPLE_BITS-1:0];
      return SAMPLE_BITS'(0) - qc;
    end else begin
      qc = (q > 31'((1 << (SAMPLE_BITS-1)) - 1)) ? SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1)
                                                  : q[SAMPLE_BITS-1:0];
      return qc;
    end
  endfunction

endpackage

`default_nettype wire

/* src/stereo_lookahead_peak_limiter.sv */
// Stereo look-ahead peak limiter: memory-based history with a sequenced datapath.
//
//  channel | ports                                  | payload
//  --------+----------------------------------------+---------------------------------
//  input   | in_tvalid  in_tready  in_tdata[47:0]   | left_sample, right_sample
//  output  | out_tvalid out_tready out_tdata[71:0]  | left_out, right_out, gain
//  config  | cfg_valid  cfg_ready  cfg_index cfg_data | register index, write data
//
// Each item runs through a scan of the history memories (one entry per cycle on the read
// port), a restoring division for the gain, and the states for accept, multiplies,
// averaging, saturation and write-back. A zero average skips the division. Bypass items
// go from accept straight to the output register. After reset a clearing pass zeroes
// both memories before the first input transfer; config writes are always taken.
// A finished result waits in the output register while the next item is processed.
`default_nettype none

module stereo_lookahead_peak_limiter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // left_sample[23:0], right_sample[47:24]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // left_out[23:0], right_out[47:24], gain[71:48]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int SB = slpl_pkg::SAMPLE_BITS;
  localparam int EW = slpl_pkg::ENV_W;
  localparam int AW = 2 * SB + EW;

  // Configuration registers
  logic [31:0] attack_r, release_r;
  logic [24:0] thresh_r, invb_r;
  logic [23:0] makeup_r, beta_r;
  logic        bypass_r;

  // Sequencer
  slpl_pkg::state_t    state_r, state_nxt;
  logic [slpl_pkg::SCAN_W-1:0] scan_cnt_r;
  logic                rd_vld_r;
  logic [slpl_pkg::DLY_AW-1:0] rd_idx_r;

  // Persistent scalar state
  logic [slpl_pkg::DLY_AW-1:0] dpos_r;
  logic [slpl_pkg::AVG_AW-1:0] epos_r;
  logic [EW-1:0] env_prev_r, avg_prev_r;

  // Per-item working registers
  logic [SB-1:0] l_in_r, r_in_r, dly_l_r, dly_r_r;
  logic [EW-1:0] peak_r, c_r, wmax_r, emax_r, old_r, avg_r;
  logic [34:0]   sum_r;
  logic [28:0]   qsum_r;
  logic          above_r, up_r;
  logic [slpl_pkg::GAIN_W-1:0] g_r;
  logic [SB-1:0] res_l_r, res_r_r;
  logic [slpl_pkg::GAIN_W-1:0] res_g_r;

  // Shared multiplier and divider
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  logic [slpl_pkg::DVD_W-1:0] dvd_r, quo_r;
  logic [EW-1:0] dvs_r, rem_r;
  logic [slpl_pkg::DIVC_W-1:0] div_cnt_r;

  // Memories
  logic [AW-1:0] mem_a [slpl_pkg::DELAY_LEN];
  logic [EW-1:0] mem_e [slpl_pkg::AVG_LEN];
  logic [AW-1:0] rd_a_q;
  logic [EW-1:0] rd_e_q;
  logic          a_we, e_we;
  logic [slpl_pkg::DLY_AW-1:0] a_wa, a_ra;
  logic [slpl_pkg::AVG_AW-1:0] e_wa, e_ra;
  logic [AW-1:0] a_wd;
  logic [EW-1:0] e_wd;

  // Combinational helpers
  logic [slpl_pkg::DLY_AW-1:0] dnext;
  logic [slpl_pkg::AVG_AW-1:0] enext;
  logic        in_xfer, out_load;
  logic [SB:0] ml, mr, pk;
  logic [28:0] trial;
  logic        ge;
  logic [29:0] avg_sum;
  logic [EW-1:0] avg_calc, b_val, d_val;
  logic [28:0] t_val;
  logic [29:0] dn_val;
  logic [30:0] up_sum;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == slpl_pkg::S_DONE) && (!out_tvalid || out_tready);

  assign dnext = (dpos_r == slpl_pkg::DLY_AW'(slpl_pkg::DELAY_LEN - 1)) ? '0 : dpos_r + 1'b1;
  assign enext = (epos_r == slpl_pkg::AVG_AW'(slpl_pkg::AVG_LEN - 1)) ? '0 : epos_r + 1'b1;

  assign ml = slpl_pkg::mag(in_tdata[SB-1:0]);
  assign mr = slpl_pkg::mag(in_tdata[2*SB-1:SB]);
  assign pk = (ml > mr) ? ml : mr;

  assign trial   = {rem_r, dvd_r[slpl_pkg::DVD_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  // Sum quotient plus oldest-entry quotient from the reciprocal product
  assign avg_sum = {1'b0, qsum_r} + {8'b0, prod_r[57:36]};
  assign avg_calc = (avg_sum > 30'(slpl_pkg::ENV_MAX)) ? slpl_pkg::ENV_MAX : avg_sum[EW-1:0];

  assign b_val  = prod_r[51:24];
  assign t_val  = prod_r[52:24];
  assign d_val  = (wmax_r > env_prev_r) ? wmax_r - env_prev_r : env_prev_r - wmax_r;
  assign dn_val = prod_r[59:30];
  assign up_sum = {3'b0, env_prev_r} + {1'b0, dn_val};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= 32'd1180000000;
      release_r <= 32'd894785;
      thresh_r  <= 25'd16777216;
      makeup_r  <= 24'd262144;
      beta_r    <= 24'd7000;
      invb_r    <= 25'd16784000;
      bypass_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slpl_pkg::CFG_ATTACK:  attack_r  <= cfg_data;
        slpl_pkg::CFG_RELEASE: release_r <= cfg_data;
        slpl_pkg::CFG_THRESH:  thresh_r  <= cfg_data[24:0];
        slpl_pkg::CFG_MAKEUP:  makeup_r  <= cfg_data[23:0];
        slpl_pkg::CFG_BETA:    beta_r    <= cfg_data[23:0];
        slpl_pkg::CFG_INVB:    invb_r    <= cfg_data[24:0];
        slpl_pkg::CFG_BYPASS:  bypass_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slpl_pkg::S_CLEAR:
        if (scan_cnt_r == slpl_pkg::SCAN_W'(slpl_pkg::DELAY_LEN - 1)) state_nxt = slpl_pkg::S_IDLE;
      slpl_pkg::S_IDLE:
        if (in_xfer) state_nxt = bypass_r ? slpl_pkg::S_DONE : slpl_pkg::S_SCAN;
      slpl_pkg::S_SCAN:
        if (scan_cnt_r == slpl_pkg::SCAN_W'(slpl_pkg::DELAY_LEN)) state_nxt = slpl_pkg::S_MUL_B;
      slpl_pkg::S_MUL_B: state_nxt = slpl_pkg::S_MUL_T;
      slpl_pkg::S_MUL_T: state_nxt = slpl_pkg::S_CORR;
      slpl_pkg::S_CORR:  state_nxt = slpl_pkg::S_MUL_E;
      slpl_pkg::S_MUL_E: state_nxt = slpl_pkg::S_ENV;
      slpl_pkg::S_ENV:   state_nxt = slpl_pkg::S_MUL_S;
      slpl_pkg::S_MUL_S: state_nxt = slpl_pkg::S_MUL_O;
      slpl_pkg::S_MUL_O: state_nxt = slpl_pkg::S_AVG;
      slpl_pkg::S_AVG:
        state_nxt = (avg_calc == '0) ? slpl_pkg::S_MUL_L1 : slpl_pkg::S_DIV;
      slpl_pkg::S_DIV:
        if (div_cnt_r == '0) state_nxt = slpl_pkg::S_DIV_END;
      slpl_pkg::S_DIV_END: state_nxt = slpl_pkg::S_MUL_L1;
      slpl_pkg::S_MUL_L1: state_nxt = slpl_pkg::S_MUL_L2;
      slpl_pkg::S_MUL_L2: state_nxt = slpl_pkg::S_SAT_L;
      slpl_pkg::S_SAT_L:  state_nxt = slpl_pkg::S_MUL_R1;
      slpl_pkg::S_MUL_R1: state_nxt = slpl_pkg::S_MUL_R2;
      slpl_pkg::S_MUL_R2: state_nxt = slpl_pkg::S_SAT_R;
      slpl_pkg::S_SAT_R:  state_nxt = slpl_pkg::S_WRITE;
      slpl_pkg::S_WRITE:  state_nxt = slpl_pkg::S_DONE;
      slpl_pkg::S_DONE:
        if (out_load) state_nxt = slpl_pkg::S_IDLE;
      default: state_nxt = slpl_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshake, memory ports, multiplier operands
  always_comb begin
    in_tready = (state_r == slpl_pkg::S_IDLE);
    a_we  = 1'b0;
    e_we  = 1'b0;
    a_wa  = scan_cnt_r[slpl_pkg::DLY_AW-1:0];
    e_wa  = scan_cnt_r[slpl_pkg::AVG_AW-1:0];
    a_wd  = '0;
    e_wd  = '0;
    a_ra  = scan_cnt_r[slpl_pkg::DLY_AW-1:0];
    e_ra  = (scan_cnt_r < slpl_pkg::SCAN_W'(slpl_pkg::AVG_LEN))
          ? scan_cnt_r[slpl_pkg::AVG_AW-1:0] : '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      slpl_pkg::S_CLEAR: begin
        a_we = 1'b1;
        e_we = scan_cnt_r < slpl_pkg::SCAN_W'(slpl_pkg::AVG_LEN);
      end
      slpl_pkg::S_MUL_B: begin
        mul_a = {8'b0, beta_r};
        mul_b = {4'b0, avg_prev_r};
      end
      slpl_pkg::S_MUL_T: begin
        mul_a = {4'b0, peak_r - b_val};
        mul_b = {7'b0, invb_r};
      end
      slpl_pkg::S_MUL_E: begin
        mul_a = (wmax_r > env_prev_r) ? attack_r : release_r;
        mul_b = {4'b0, d_val};
      end
      slpl_pkg::S_MUL_S: begin
        mul_a = sum_r[34:3];
        mul_b = slpl_pkg::DIV15_MUL;
      end
      slpl_pkg::S_MUL_O: begin
        mul_a = {4'b0, old_r};
        mul_b = slpl_pkg::DIV121_MUL;
      end
      slpl_pkg::S_MUL_L1: begin
        mul_a = {7'b0, slpl_pkg::mag(dly_l_r)};
        mul_b = {8'b0, g_r};
      end
      slpl_pkg::S_MUL_L2, slpl_pkg::S_MUL_R2: begin
        mul_a = {7'b0, prod_r[47:23]};
        mul_b = {8'b0, makeup_r};
      end
      slpl_pkg::S_MUL_R1: begin
        mul_a = {7'b0, slpl_pkg::mag(dly_r_r)};
        mul_b = {8'b0, g_r};
      end
      slpl_pkg::S_WRITE: begin
        a_we = 1'b1;
        e_we = 1'b1;
        a_wa = dnext;
        e_wa = enext;
        a_wd = {c_r, r_in_r, l_in_r};
        e_wd = emax_r;
      end
      default: ;
    endcase
  end

  // History memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_wa] <= a_wd;
    rd_a_q <= mem_a[a_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) mem_e[e_wa] <= e_wd;
    rd_e_q <= mem_e[e_ra];
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= slpl_pkg::S_CLEAR;
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      dpos_r     <= '0;
      epos_r     <= '0;
      env_prev_r <= '0;
      avg_prev_r <= '0;
      out_tvalid <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == slpl_pkg::S_SCAN)
               && (scan_cnt_r < slpl_pkg::SCAN_W'(slpl_pkg::DELAY_LEN));

      // Advance sweep counter
      if (state_r == slpl_pkg::S_IDLE) begin
        scan_cnt_r <= '0;
      end else if ((state_r == slpl_pkg::S_CLEAR) || (state_r == slpl_pkg::S_SCAN)) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end

      // Divider step count
      if (state_r == slpl_pkg::S_DIV) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end else begin
        div_cnt_r <= slpl_pkg::DIVC_W'(slpl_pkg::DVD_W - 1);
      end

      // Commit state of the item
      if (state_r == slpl_pkg::S_WRITE) begin
        dpos_r     <= dnext;
        epos_r     <= enext;
        env_prev_r <= emax_r;
        avg_prev_r <= avg_r;
      end

      // Output register
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    unique case (state_r)
      slpl_pkg::S_IDLE: begin
        l_in_r <= in_tdata[SB-1:0];
        r_in_r <= in_tdata[2*SB-1:SB];
        peak_r <= {2'b0, pk, 1'b0};
        wmax_r <= '0;
        sum_r  <= '0;
        if (bypass_r) begin
          res_l_r <= in_tdata[SB-1:0];
          res_r_r <= in_tdata[2*SB-1:SB];
          res_g_r <= slpl_pkg::GAIN_ONE;
        end
      end
      slpl_pkg::S_SCAN: begin
        // Fold the returning read into max, sum and captures
        if (rd_vld_r) begin
          if (rd_a_q[AW-1:2*SB] > wmax_r) wmax_r <= rd_a_q[AW-1:2*SB];
          if (rd_idx_r < slpl_pkg::DLY_AW'(slpl_pkg::AVG_LEN)) begin
            sum_r <= sum_r + {7'b0, rd_e_q};
            if (rd_idx_r == {2'b0, enext}) old_r <= rd_e_q;
          end
          if (rd_idx_r == dnext) begin
            dly_l_r <= rd_a_q[SB-1:0];
            dly_r_r <= rd_a_q[2*SB-1:SB];
          end
        end
      end
      slpl_pkg::S_MUL_T: above_r <= peak_r > b_val;
      slpl_pkg::S_CORR: begin
        if (above_r && (t_val > {1'b0, peak_r})) begin
          c_r <= t_val[28] ? slpl_pkg::ENV_MAX : t_val[EW-1:0];
        end else begin
          c_r <= peak_r;
        end
      end
      slpl_pkg::S_MUL_E: up_r <= wmax_r > env_prev_r;
      slpl_pkg::S_ENV: begin
        if (up_r) begin
          emax_r <= (up_sum > 31'(slpl_pkg::ENV_MAX)) ? slpl_pkg::ENV_MAX : up_sum[EW-1:0];
        end else begin
          emax_r <= (dn_val >= {2'b0, env_prev_r}) ? '0 : env_prev_r - dn_val[EW-1:0];
        end
      end
      // Take the sum quotient from the reciprocal product
      slpl_pkg::S_MUL_O: qsum_r <= prod_r[63:35];
      slpl_pkg::S_AVG: begin
        avg_r <= avg_calc;
        g_r   <= slpl_pkg::GAIN_ONE;
        dvd_r <= {thresh_r, 23'b0};
        dvs_r <= avg_calc;
        rem_r <= '0;
      end
      slpl_pkg::S_DIV: begin
        // One restoring quotient bit per cycle
        rem_r <= ge ? EW'(trial - {1'b0, dvs_r}) : trial[EW-1:0];
        dvd_r <= {dvd_r[slpl_pkg::DVD_W-2:0], 1'b0};
        quo_r <= {quo_r[slpl_pkg::DVD_W-2:0], ge};
      end
      slpl_pkg::S_DIV_END: begin
        g_r <= (quo_r > slpl_pkg::DVD_W'(slpl_pkg::GAIN_ONE))
             ? slpl_pkg::GAIN_ONE : quo_r[slpl_pkg::GAIN_W-1:0];
      end
      slpl_pkg::S_SAT_L: res_l_r <= slpl_pkg::sat_out(prod_r[48:18], dly_l_r[SB-1]);
      slpl_pkg::S_SAT_R: res_r_r <= slpl_pkg::sat_out(prod_r[48:18], dly_r_r[SB-1]);
      slpl_pkg::S_WRITE: res_g_r <= g_r;
      default: ;
    endcase

    rd_idx_r <= scan_cnt_r[slpl_pkg::DLY_AW-1:0];

    // Hold result until the output register is free
    if (out_load) out_tdata <= {res_g_r, res_r_r, res_l_r};
  end

  // Checks on the sequencer and datapath
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dpos_r < slpl_pkg::DLY_AW'(slpl_pkg::DELAY_LEN))
    && (epos_r < slpl_pkg::AVG_AW'(slpl_pkg::AVG_LEN)))
    else $error("history pointer out of range");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpl_pkg::S_SCAN) |-> (scan_cnt_r <= slpl_pkg::SCAN_W'(slpl_pkg::DELAY_LEN)))
    else $error("scan ran past history depth");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpl_pkg::S_DIV) |=> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_gain_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpl_pkg::S_MUL_L1) |-> (g_r <= slpl_pkg::GAIN_ONE))
    else $error("gain above unity");

  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpl_pkg::S_WRITE) |=> (state_r == slpl_pkg::S_DONE) && $changed(dpos_r))
    else $error("item commit did not advance history");

endmodule

`default_nettype wire

/* tb/slpl_checker.sv */
// Checker for the stereo peak limiter: watches all channels, predicts results and compares.
`default_nettype none

module slpl_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,   // left_sample[23:0], right_sample[47:24]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,  // left_out[23:0], right_out[47:24], gain[71:48]
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [23:0] left_out;
    logic [23:0] right_out;
    logic [23:0] gain;
  } limited_pair_t;

  localparam u64_t SMP_MASK = (u64_t'(1) << slpl_pkg::SAMPLE_BITS) - 1;
  localparam u64_t SMP_HALF = u64_t'(1) << (slpl_pkg::SAMPLE_BITS - 1);
  localparam u64_t ENV_TOP  = u64_t'(slpl_pkg::ENV_MAX);
  localparam u64_t UNITY    = u64_t'(slpl_pkg::GAIN_ONE);

  // Register copies
  u64_t attack_r, release_r, thresh_r, makeup_r, beta_r, invb_r;
  logic bypass_r;

  // Limiter state copies
  u64_t hold_l [slpl_pkg::DELAY_LEN];
  u64_t hold_r [slpl_pkg::DELAY_LEN];
  u64_t peaks  [slpl_pkg::DELAY_LEN];
  u64_t envs   [slpl_pkg::AVG_LEN];
  int   wr_dly, wr_env;
  u64_t last_env, last_avg;

  limited_pair_t expected_pairs[$];

  function automatic u64_t abs_sample(input u64_t v);
    v &= SMP_MASK;
    return (v & SMP_HALF) ? (SMP_MASK + 1 - v) : v;
  endfunction

  // Scale a delayed sample by gain and makeup, restore sign, clamp
  function automatic logic [23:0] scale_sample(input u64_t s, input u64_t g);
    u64_t q;
    q = (((abs_sample(s) * g) >> 23) * makeup_r) >> 18;
    if (s & SMP_HALF) begin
      if (q > SMP_HALF) q = SMP_HALF;
      return 24'((0 - q) & SMP_MASK);
    end
    if (q > SMP_HALF - 1) q = SMP_HALF - 1;
    return 24'(q);
  endfunction

  task automatic limit_pair(input logic [23:0] l, input logic [23:0] r);
    u64_t ml, mr, pk, b, c, t, wmax, emax, dn, sum, avg, g;
    int dnext, enext;
    limited_pair_t res;
    if (bypass_r) begin
      res.left_out = l;
      res.right_out = r;
      res.gain = 24'(UNITY);
      expected_pairs.push_back(res);
      return;
    end
    ml = abs_sample(u64_t'(l));
    mr = abs_sample(u64_t'(r));
    pk = (ml > mr ? ml : mr) << 1;
    if (pk > ENV_TOP) pk = ENV_TOP;
    // Corrected peak
    c = pk;
    b = (beta_r * last_avg) >> 24;
    if (pk > b) begin
      t = ((pk - b) * invb_r) >> 24;
      if (t > c) c = t;
    end
    if (c > ENV_TOP) c = ENV_TOP;
    // Window maximum and envelope smoothing
    wmax = 0;
    foreach (peaks[i]) if (peaks[i] > wmax) wmax = peaks[i];
    if (wmax > last_env) begin
      emax = last_env + ((attack_r * (wmax - last_env)) >> 30);
      if (emax > ENV_TOP) emax = ENV_TOP;
    end else begin
      dn = (release_r * (last_env - wmax)) >> 30;
      emax = (dn >= last_env) ? 0 : last_env - dn;
    end
    // Average of the envelope history plus the oldest entry
    enext = (wr_env + 1) % slpl_pkg::AVG_LEN;
    sum = 0;
    foreach (envs[i]) sum += envs[i];
    avg = sum / slpl_pkg::AVG_LEN + envs[enext] / (slpl_pkg::AVG_LEN + 1);
    if (avg > ENV_TOP) avg = ENV_TOP;
    if (avg == 0) begin
      g = UNITY;
    end else begin
      g = (thresh_r << 23) / avg;
      if (g > UNITY) g = UNITY;
    end
    dnext = (wr_dly + 1) % slpl_pkg::DELAY_LEN;
    res.left_out = scale_sample(hold_l[dnext], g);
    res.right_out = scale_sample(hold_r[dnext], g);
    res.gain = 24'(g);
    expected_pairs.push_back(res);
    // Advance state
    envs[enext] = emax;
    wr_env = enext;
    peaks[dnext] = c;
    hold_l[dnext] = u64_t'(l);
    hold_r[dnext] = u64_t'(r);
    wr_dly = dnext;
    last_env = emax;
    last_avg = avg;
  endtask

  initial begin
    attack_r = 1180000000;
    release_r = 894785;
    thresh_r = 16777216;
    makeup_r = 262144;
    beta_r = 7000;
    invb_r = 16784000;
    bypass_r = 1'b0;
    foreach (hold_l[i]) begin
      hold_l[i] = 0;
      hold_r[i] = 0;
      peaks[i] = 0;
    end
    foreach (envs[i]) envs[i] = 0;
    wr_dly = 0;
    wr_env = 0;
    last_env = 0;
    last_avg = 0;
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
  end

  // Track register writes
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        slpl_pkg::CFG_ATTACK:  attack_r  = u64_t'(cfg_data);
        slpl_pkg::CFG_RELEASE: release_r = u64_t'(cfg_data);
        slpl_pkg::CFG_THRESH:  thresh_r  = u64_t'(cfg_data[24:0]);
        slpl_pkg::CFG_MAKEUP:  makeup_r  = u64_t'(cfg_data[23:0]);
        slpl_pkg::CFG_BETA:    beta_r    = u64_t'(cfg_data[23:0]);
        slpl_pkg::CFG_INVB:    invb_r    = u64_t'(cfg_data[24:0]);
        slpl_pkg::CFG_BYPASS:  bypass_r  = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Compare each output transfer with the oldest prediction, predict on each input transfer
  always @(posedge clk) begin
    limited_pair_t exp_p;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (expected_pairs.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transfer: %h", out_tdata);
      end else begin
        exp_p = expected_pairs.pop_front();
        if (exp_p.left_out !== out_tdata[23:0] || exp_p.right_out !== out_tdata[47:24] ||
            exp_p.gain !== out_tdata[71:48]) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: expected L=%h R=%h G=%h, got L=%h R=%h G=%h",
                     result_count, exp_p.left_out, exp_p.right_out, exp_p.gain,
                     out_tdata[23:0], out_tdata[47:24], out_tdata[71:48]);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) limit_pair(in_tdata[23:0], in_tdata[47:24]);
    pending_count = expected_pairs.size();
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Top of the stereo peak limiter testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 12000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // left_sample[23:0], right_sample[47:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // left_out[23:0], right_out[47:24], gain[71:48]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count, pending_count, result_count;
  int cycles;
  int sent_count;
  int phase_count;
  bit long_hold_req;

  stereo_lookahead_peak_limiter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slpl_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 40);
    return $urandom_range(100, 900);
  endfunction

  // Receiver: random stalls, free-running stretches, one long hold-off on request
  initial begin
    int len;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (4000) @(posedge clk);
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(200, 3000)) @(posedge clk);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_tready <= 1'b0;
          repeat (len) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Offer one pair and hold it until the transfer
  task automatic send_pair(input logic [23:0] l, input logic [23:0] r, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r, l};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [31:0] att, input logic [31:0] rel,
                               input logic [31:0] thr, input logic [31:0] mk,
                               input logic [31:0] bt, input logic [31:0] ib,
                               input logic [31:0] bp);
    write_reg(slpl_pkg::CFG_ATTACK, att);
    write_reg(slpl_pkg::CFG_RELEASE, rel);
    write_reg(slpl_pkg::CFG_THRESH, thr);
    write_reg(slpl_pkg::CFG_MAKEUP, mk);
    write_reg(slpl_pkg::CFG_BETA, bt);
    write_reg(slpl_pkg::CFG_INVB, ib);
    write_reg(slpl_pkg::CFG_BYPASS, bp);
    write_reg(CFG_UNUSED, $urandom);
    phase_count++;
  endtask

  // Random sample: full range, a random level, or near silence
  function automatic logic [23:0] rand_sample();
    int k;
    logic [23:0] v;
    case ($urandom_range(0, 3))
      0: v = 24'($urandom);
      1: begin
        k = $urandom_range(1, 23);
        v = 24'($urandom & ((32'd1 << k) - 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      2: v = 24'($urandom_range(0, 15)) - 24'd8;
      default: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
    return v;
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample(), pick_gap());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    long_hold_req = 1'b0;
    sent_count = 0;
    phase_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes at reset settings
    send_pair(24'h000000, 24'h000000, 0);
    send_pair(24'h7FFFFF, 24'h800000, 0);
    send_pair(24'h800000, 24'h7FFFFF, 0);
    send_pair(24'hFFFFFF, 24'h000001, 2);
    send_pair(24'h800000, 24'h800000, 0);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 0);
    send_pair(24'h400000, 24'hC00000, 1);
    send_pair(24'h000000, 24'h000000, 0);
    send_pair(24'h555555, 24'hAAAAAA, 0);
    send_pair(24'hAAAAAA, 24'h555555, 0);
    drain();

    // Directed: bypass passes pairs through untouched
    load_settings(1180000000, 894785, 16777216, 262144, 7000, 16784000, 1);
    send_pair(24'h800000, 24'h7FFFFF, 0);
    send_pair(24'h123456, 24'hFEDCBA, 0);
    send_pair(24'h000000, 24'hFFFFFF, 0);
    drain();

    // Directed: zero threshold and release, every other coefficient at its top
    load_settings(32'hFFFF_FFFF, 0, 0, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h01FF_FFFF, 0);
    send_pair(24'h7FFFFF, 24'h800000, 0);
    send_pair(24'h800000, 24'h000000, 0);
    send_pair(24'h000000, 24'h7FFFFF, 0);
    send_pair(24'h000001, 24'hFFFFFF, 0);
    random_run(185);
    drain();

    // Frozen attack, fastest release, threshold at its reset value, muted output
    load_settings(0, 32'hFFFF_FFFF, 32'h0100_0000, 0, 0, 0, 0);
    random_run(190);
    drain();

    // Typical limiting with a long receiver hold-off to back up the input
    load_settings(1180000000, 894785, 4194304, 524288, 7000, 16784000, 0);
    long_hold_req = 1'b1;
    random_run(200);
    drain();

    // Bypass with random other registers
    load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
    random_run(190);
    drain();

    // Fully random register contents
    load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    random_run(190);
    drain();

    // Unity attack, mild release, half threshold, strong correction
    load_settings(32'h4000_0000, 32'h2000_0000, 8388608, 32'h0007_FFFF,
                  32'h0080_0000, 32'h01FF_FFFF, 0);
    random_run(195);

    // Wind down
    drain();
    repeat (700) @(posedge clk);
    if (pending_count != 0) $display("%0d results never arrived", pending_count);
    $display("covered %0d pairs over %0d register settings, %0d results checked",
             sent_count, phase_count + 1, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
